// File: rtl/core/pngd_pkg.sv
// Package for the PNG chunk deframer: phase and result-kind codes, the result record
// type and the fixed field sizes. It has no dependencies.
`default_nettype none

package pngd_pkg;

    localparam logic [31:0] SIG_BYTES = 32'd8;
    localparam logic [31:0] HDR_BYTES = 32'd8;
    localparam logic [31:0] CRC_BYTES = 32'd4;
    localparam logic [1:0]  FIELD_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_SIG     = 3'd0,
        PH_LEN     = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CHUNK   = 2'd1,
        KIND_OVERRUN = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic [31:0] chunk_crc;
    } t_rec;

endpackage

`default_nettype wire

// File: rtl/core/pngd_if.sv
// Valid/ready channel interfaces for the PNG chunk deframer: the file byte stream,
// the result stream and the size register write. They depend on pngd_pkg.
`default_nettype none

interface pngd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pngd_rec_if;
    logic               valid;
    logic               ready;
    pngd_pkg::t_kind    kind;
    logic [7:0]         payload_byte;
    logic [31:0]        chunk_length;
    logic [31:0]        chunk_type;
    logic [31:0]        chunk_crc;
    modport source (output valid, output kind, output payload_byte, output chunk_length,
                    output chunk_type, output chunk_crc, input ready);
    modport sink   (input valid, input kind, input payload_byte, input chunk_length,
                    input chunk_type, input chunk_crc, output ready);
endinterface

interface pngd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] total_bytes;
    modport source (output valid, output total_bytes, input ready);
    modport sink   (input valid, input total_bytes, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pngd_out_stage.sv
// Result register of the PNG chunk deframer: holds one record until the sink takes it.
// Depends on pngd_pkg and pngd_rec_if.
`default_nettype none

module pngd_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  pngd_pkg::t_rec i_rec,
    output logic           o_ready,
    pngd_rec_if.source     o_rec
);
    import pngd_pkg::*;

    logic r_valid;
    t_rec r_rec;

    assign o_ready = !r_valid || o_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec.valid        = r_valid;
    assign o_rec.kind         = r_rec.kind;
    assign o_rec.payload_byte = r_rec.payload_byte;
    assign o_rec.chunk_length = r_rec.chunk_length;
    assign o_rec.chunk_type   = r_rec.chunk_type;
    assign o_rec.chunk_crc    = r_rec.chunk_crc;

endmodule

`default_nettype wire

// File: rtl/core/png_chunk_deframer.sv
// Top level of the PNG chunk deframer: chunk parser state machine and size register.
// Depends on pngd_pkg, the interfaces in pngd_if and pngd_out_stage.
//
//   channel  dir  beat
//   i_cfg    in   total_bytes, file size in bytes (always ready)
//   i_byte   in   data_byte, next file byte
//   o_rec    out  kind, payload_byte, chunk_length, chunk_type, chunk_crc
//
// One byte per cycle while i_byte.ready is high; a byte's record, if any, appears on o_rec the next cycle.
// The parser updates its state on the accepting edge; the result register holds
// a record while o_rec stalls and i_byte.ready drops only when it is full and held.
// Synchronous active-low reset returns to the signature phase with zero size.
`default_nettype none

module png_chunk_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pngd_cfg_if.sink    i_cfg,
    pngd_byte_if.sink   i_byte,
    pngd_rec_if.source  o_rec
);
    import pngd_pkg::*;

    logic [31:0] r_total;
    logic [31:0] r_pos,  n_pos;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_fc,   n_fc;
    logic [31:0] r_len,  n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_crc,  n_crc;
    logic [31:0] r_left, n_left;

    logic        w_take;
    logic        w_stage_ready;
    logic        w_emit;
    t_rec        w_rec;
    logic [7:0]  w_b;
    logic        w_short;
    logic        w_over;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = w_stage_ready;
    assign w_take       = i_byte.valid && w_stage_ready;
    assign w_b          = i_byte.data_byte;

    assign w_short = ({1'b0, r_pos} + {1'b0, HDR_BYTES}) > {1'b0, r_total};
    assign w_over  = ({2'b00, r_pos} + 34'd1 + {2'b00, r_len} + {2'b00, CRC_BYTES})
                     > {2'b00, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg.valid) begin
            r_total <= i_cfg.total_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_SIG;
            r_fc    <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_crc   <= '0;
            r_left  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_fc    = r_fc;
        n_len   = r_len;
        n_type  = r_type;
        n_crc   = r_crc;
        n_left  = r_left;
        w_emit  = 1'b0;
        w_rec   = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, chunk_length: r_len,
                    chunk_type: r_type, chunk_crc: 32'd0};
        if (w_take) begin
            case (r_phase)
                PH_SIG: begin
                    n_pos = r_pos + 32'd1;
                    if (n_pos >= SIG_BYTES) begin
                        n_phase = PH_LEN;
                        n_fc    = '0;
                    end
                end
                PH_LEN: begin
                    if (r_fc == 2'd0 && w_short) begin
                        n_phase = PH_DONE;
                    end else begin
                        if (r_fc == 2'd0) begin
                            n_len  = {24'd0, w_b};
                            n_type = '0;
                            n_crc  = '0;
                        end else begin
                            n_len = {r_len[23:0], w_b};
                        end
                        n_pos = r_pos + 32'd1;
                        if (r_fc == FIELD_LAST) begin
                            n_fc    = '0;
                            n_phase = PH_TYPE;
                        end else begin
                            n_fc = r_fc + 2'd1;
                        end
                    end
                end
                PH_TYPE: begin
                    n_type = {r_type[23:0], w_b};
                    n_pos  = r_pos + 32'd1;
                    if (r_fc != FIELD_LAST) begin
                        n_fc = r_fc + 2'd1;
                    end else begin
                        n_fc = '0;
                        if (w_over) begin
                            n_phase          = PH_DONE;
                            w_emit           = 1'b1;
                            w_rec.kind       = KIND_OVERRUN;
                            w_rec.chunk_type = n_type;
                        end else begin
                            n_left  = r_len;
                            n_phase = (r_len == 32'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    w_emit             = 1'b1;
                    w_rec.payload_byte = w_b;
                    n_pos              = r_pos + 32'd1;
                    n_left             = r_left - 32'd1;
                    if (n_left == 32'd0) begin
                        n_phase = PH_CRC;
                        n_fc    = '0;
                    end
                end
                PH_CRC: begin
                    n_crc = {r_crc[23:0], w_b};
                    n_pos = r_pos + 32'd1;
                    if (r_fc != FIELD_LAST) begin
                        n_fc = r_fc + 2'd1;
                    end else begin
                        n_fc            = '0;
                        n_phase         = PH_LEN;
                        w_emit          = 1'b1;
                        w_rec.kind      = KIND_CHUNK;
                        w_rec.chunk_crc = n_crc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    pngd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_rec   (w_rec),
        .o_ready (w_stage_ready),
        .o_rec   (o_rec)
    );

endmodule

`default_nettype wire
